>>> hw/rtl/vcg_pkg.sv
`timescale 1ns / 1ps

package vcg_pkg;

  // register file layout
  localparam int CFG_WIDTH         = 15;
  localparam int CFG_INDEX_WIDTH   = 2;
  localparam int DEF_SAMPLE_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHANGE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_SPEED        = 2'd1;

  localparam logic [CFG_WIDTH-1:0] CHANGE_THRESHOLD_RESET = 15'd410;
  localparam logic [CFG_WIDTH-1:0] MAX_SPEED_RESET        = 15'd3072;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_MWAIT,
    S_ROOT,
    S_ROOTW,
    S_SCMUL,
    S_SCMW,
    S_DIVW,
    S_FIN
  } state_t;

  // squaring pass slots, low two bits select the axis
  typedef enum logic [2:0] {
    MOP_DX,
    MOP_DY,
    MOP_DZ,
    MOP_THR,
    MOP_VX,
    MOP_VY,
    MOP_VZ,
    MOP_MAX
  } mop_t;

  // root/divide unit operation
  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> hw/rtl/vcg_mul.sv
`timescale 1ns / 1ps

module vcg_mul #(
  parameter int MW = 16
) (
  input  logic            clk,
  input  logic [MW-1:0]   a,
  input  logic [MW-1:0]   b,
  output logic [2*MW-1:0] p
);

  // registered unsigned product, operands held by the sequencer
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> hw/rtl/vcg_rootdiv.sv
`timescale 1ns / 1ps

module vcg_rootdiv #(
  parameter int W  = 16,
  parameter int MW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vcg_pkg::unit_cmd_t   cmd,
  input  logic [2*MW+1:0]      radicand,
  input  logic [2*MW-1:0]      dividend,
  input  logic [MW:0]          divisor,
  output vcg_pkg::unit_stat_t  stat,
  output logic [MW:0]          result
);
  import vcg_pkg::*;

  localparam int SW  = 2 * MW + 2;
  localparam int RW  = MW + 1;
  localparam int RMW = MW + 3;
  localparam int CW  = $clog2(RW + 1);

  logic [SW-1:0]  src;
  logic [RMW-1:0] rem;
  logic [RW-1:0]  res;
  logic [RW-1:0]  dvs;
  unit_op_t       op_q;
  logic [CW-1:0]  cnt;
  logic           done;

  logic [RMW-1:0] shifted;
  logic [RMW-1:0] trial;
  logic [RMW-1:0] diff;
  logic           ge;
  logic [SW-1:0]  src_next;
  logic [2*MW+RMW-1:0] numx;

  // one restoring step: two radicand bits for the root, one dividend bit for the quotient
  always_comb begin
    if (op_q == OP_SQRT) begin
      shifted  = {rem[RMW-3:0], src[SW-1 -: 2]};
      trial    = {res, 2'b01};
      src_next = src << 2;
    end else begin
      shifted  = {rem[RMW-2:0], src[SW-1]};
      trial    = {2'b00, dvs};
      src_next = src << 1;
    end
    diff = shifted - trial;
    ge   = shifted >= trial;
  end

  // high part of the dividend seeds the remainder, it stays below the divisor
  assign numx = {{RMW{1'b0}}, dividend};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (cmd.start) begin
      op_q <= cmd.op;
      res  <= '0;
      dvs  <= divisor;
      done <= 1'b0;
      if (cmd.op == OP_SQRT) begin
        src <= radicand;
        rem <= '0;
        cnt <= CW'(RW);
      end else begin
        src <= {dividend[W-1:0], {(SW-W){1'b0}}};
        rem <= numx[W +: RMW];
        cnt <= CW'(W);
      end
    end else if (cnt != '0) begin
      src  <= src_next;
      rem  <= ge ? diff : shifted;
      res  <= {res[RW-2:0], ge};
      cnt  <= cnt - CW'(1);
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign result    = res;

  // never restarted mid-run
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> cnt == '0)
    else $error("root/divide unit restarted while busy");

  // completion is a single pulse after the last step
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (cnt == '0) && !$past(done))
    else $error("root/divide done pulse malformed");

  // a divide never starts against a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && cmd.op == OP_DIV) |-> divisor != '0)
    else $error("divide started with zero divisor");

endmodule

>>> hw/rtl/velocity_change_gate_norm_limiter.sv
`timescale 1ns / 1ps
// channel  | signals                              | direction
// ---------+--------------------------------------+----------
// in       | in_valid, in_ready, vel_x/y/z        | input word
// out      | out_valid, out_ready, ref_x/y/z      | output word
// cfg      | cfg_we, cfg_addr, cfg_data           | register write
//
// one word at a time; the shared multiplier takes eight squaring slots, each
// an S_MUL state followed by an S_MWAIT state
// limiting adds the bit-serial root and then three serial divides, one per axis
// the first word after reset is answered with zero, going from S_IDLE straight to S_FIN
// rst is synchronous; in_ready is low in reset and while a word is in flight, a
// finished word waits in the output register and the next input is taken meanwhile

module velocity_change_gate_norm_limiter #(
  parameter int SAMPLE_WIDTH = vcg_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      vel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]      vel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]      vel_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      ref_x,
  output logic signed [SAMPLE_WIDTH-1:0]      ref_y,
  output logic signed [SAMPLE_WIDTH-1:0]      ref_z,
  input  logic                                cfg_we,
  input  logic [vcg_pkg::CFG_INDEX_WIDTH-1:0] cfg_addr,
  input  logic [vcg_pkg::CFG_WIDTH-1:0]       cfg_data
);
  import vcg_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int MW = (W > CFG_WIDTH) ? W : CFG_WIDTH;
  localparam int SW = 2 * MW + 2;
  localparam int RW = MW + 1;

  logic [CFG_WIDTH-1:0] change_threshold;
  logic [CFG_WIDTH-1:0] max_speed;

  logic signed [W-1:0] cur  [3];
  logic signed [W-1:0] last [3];
  logic signed [W-1:0] res  [3];

  state_t          state, state_next;
  mop_t            op;
  logic [1:0]      k;
  logic [SW-1:0]   sum;
  logic            pick_cur;
  logic            first;
  logic [RW-1:0]   root;

  logic [1:0]      idx;
  logic signed [W-1:0] cur_s, last_s, v, vneg;
  logic [W:0]      d, dneg;
  logic [W-1:0]    dmag, vmag;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] p;
  logic [SW-1:0]   pw;
  logic [W-1:0]    q, qneg;

  unit_cmd_t       cmd;
  unit_stat_t      ustat;
  logic [RW-1:0]   uresult;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      change_threshold <= CHANGE_THRESHOLD_RESET;
      max_speed        <= MAX_SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CHANGE_THRESHOLD: change_threshold <= cfg_data;
        REG_MAX_SPEED:        max_speed        <= cfg_data;
        default: ;
      endcase
    end
  end

  // axis select: scaling walks k, squaring slots use the low slot bits
  always_comb begin
    if (state == S_SCMUL || state == S_SCMW || state == S_DIVW) begin
      idx = k;
    end else begin
      idx = logic'(op[1:0] == 2'd3) ? 2'd2 : op[1:0];
    end
    cur_s  = cur[idx];
    last_s = last[idx];
    d      = {cur_s[W-1], cur_s} - {last_s[W-1], last_s};
    dneg   = -d;
    dmag   = d[W] ? dneg[W-1:0] : d[W-1:0];
    v      = pick_cur ? cur_s : last_s;
    vneg   = -v;
    vmag   = v[W-1] ? vneg : v;
  end

  // multiplier operands
  always_comb begin
    mul_a = MW'(vmag);
    mul_b = MW'(max_speed);
    if (state == S_MUL || state == S_MWAIT) begin
      case (op)
        MOP_DX, MOP_DY, MOP_DZ: begin
          mul_a = MW'(dmag);
          mul_b = MW'(dmag);
        end
        MOP_THR: begin
          mul_a = MW'(change_threshold);
          mul_b = MW'(change_threshold);
        end
        MOP_VX, MOP_VY, MOP_VZ: begin
          mul_a = MW'(vmag);
          mul_b = MW'(vmag);
        end
        MOP_MAX: begin
          mul_a = MW'(max_speed);
          mul_b = MW'(max_speed);
        end
        default: ;
      endcase
    end
  end

  vcg_mul #(.MW(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  vcg_rootdiv #(.W(W), .MW(MW)) u_rootdiv (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .radicand (sum),
    .dividend (p),
    .divisor  (root),
    .stat     (ustat),
    .result   (uresult)
  );

  assign pw   = SW'(p);
  assign q    = uresult[W-1:0];
  assign qneg = -q;

  // sequencer next state and unit commands
  always_comb begin
    state_next = state;
    cmd.start  = 1'b0;
    cmd.op     = OP_SQRT;
    in_ready   = (state == S_IDLE) && !rst;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = first ? S_FIN : S_MUL;
      end
      S_MUL: state_next = S_MWAIT;
      S_MWAIT: begin
        if (op == MOP_MAX) state_next = (sum > pw) ? S_ROOT : S_FIN;
        else               state_next = S_MUL;
      end
      S_ROOT: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_SQRT;
        state_next = S_ROOTW;
      end
      S_ROOTW: begin
        if (ustat.done) state_next = S_SCMUL;
      end
      S_SCMUL: state_next = S_SCMW;
      S_SCMW: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_DIV;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (ustat.done) state_next = (k == 2'd2) ? S_FIN : S_SCMUL;
      end
      S_FIN: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      first     <= 1'b1;
      out_valid <= 1'b0;
      last[0]   <= '0;
      last[1]   <= '0;
      last[2]   <= '0;
    end else if (state == S_FIN && (!out_valid || out_ready)) begin
      first     <= 1'b0;
      out_valid <= 1'b1;
      last      <= cur;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cur[0] <= vel_x;
          cur[1] <= vel_y;
          cur[2] <= vel_z;
          op     <= MOP_DX;
          sum    <= '0;
          if (first) begin
            res[0] <= '0;
            res[1] <= '0;
            res[2] <= '0;
          end
        end
      end
      S_MWAIT: begin
        case (op)
          MOP_THR: begin
            pick_cur <= sum > pw;
            sum      <= '0;
            op       <= MOP_VX;
          end
          MOP_MAX: begin
            k <= 2'd0;
            for (int i = 0; i < 3; i++) begin
              res[i] <= pick_cur ? cur[i] : last[i];
            end
          end
          default: begin
            sum <= sum + pw;
            op  <= mop_t'(op + 3'd1);
          end
        endcase
      end
      S_ROOTW: begin
        if (ustat.done) root <= uresult;
      end
      S_DIVW: begin
        if (ustat.done) begin
          res[k] <= v[W-1] ? qneg : q;
          k      <= k + 2'd1;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          ref_x <= res[0];
          ref_y <= res[1];
          ref_z <= res[2];
        end
      end
      default: ;
    endcase
  end

  // unit is idle whenever the word is being handed to the output
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> !ustat.busy)
    else $error("output loaded while root/divide unit busy");

  // a delivered word means the first-sample flag is gone
  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !first)
    else $error("result pending while first-sample flag still set");

  // an accepted word goes to the squaring pass or straight to output
  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL || state == S_FIN))
    else $error("unexpected state after accept");

  // scaling only starts once the limit compare fired
  a_root_cause: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> ($past(state) == S_MWAIT && $past(op) == MOP_MAX))
    else $error("root started outside limit compare");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import vcg_pkg::*;

  localparam int SW          = DEF_SAMPLE_WIDTH;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 200;
  localparam int TAIL_CYCLES = 120;

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

  typedef logic signed [SW-1:0] samp_t;

  typedef struct packed {
    samp_t x;
    samp_t y;
    samp_t z;
  } vec_t;

  localparam vec_t NO_MOTION = '0;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [CFG_INDEX_WIDTH-1:0] addr;
    logic [CFG_WIDTH-1:0]       data;
    vec_t                       word;
    bit                         typed;
    vec_t                       want;
  } row_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  samp_t                      vel_x;
  samp_t                      vel_y;
  samp_t                      vel_z;
  logic                       out_valid;
  logic                       out_ready;
  samp_t                      ref_x;
  samp_t                      ref_y;
  samp_t                      ref_z;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_addr;
  logic [CFG_WIDTH-1:0]       cfg_data;

  // shadow of the block state and registers
  logic [CFG_WIDTH-1:0] thr_reg;
  logic [CFG_WIDTH-1:0] max_reg;
  vec_t                 last_in;
  bit                   first_pending;

  vec_t  pending_refs[$];
  vec_t  last_sent;
  vec_t  want;
  row_t  script[$];
  int    errors;
  int    cycles;
  bit    tx_quiet;
  bit    rx_quiet;

  velocity_change_gate_norm_limiter #(
    .SAMPLE_WIDTH(SW)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .vel_x    (vel_x),
    .vel_y    (vel_y),
    .vel_z    (vel_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ref_x    (ref_x),
    .ref_y    (ref_y),
    .ref_z    (ref_z),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] square(input logic signed [63:0] a);
    return a * a;
  endfunction

  // floor of the square root, built one bit at a time from the top
  function automatic logic [63:0] floor_root(input logic [63:0] val);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 20; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= val) r = c;
    end
    return r;
  endfunction

  // c * max_speed / root with the sign of c, truncated toward zero
  function automatic samp_t shrink(input samp_t c, input logic [63:0] root);
    logic signed [63:0] s;
    logic [63:0]        q;
    s = c;
    if (s < 0) s = -s;
    q = (64'(s) * 64'(max_reg)) / root;
    return (c < 0) ? -samp_t'(q) : samp_t'(q);
  endfunction

  function automatic vec_t limit_norm(input vec_t v);
    logic [63:0] energy;
    logic [63:0] root;
    vec_t        o;
    energy = square(v.x) + square(v.y) + square(v.z);
    if (energy <= 64'(max_reg) * 64'(max_reg)) return v;
    root = floor_root(energy);
    o.x = shrink(v.x, root);
    o.y = shrink(v.y, root);
    o.z = shrink(v.z, root);
    return o;
  endfunction

  // change gate then magnitude clamp, advances the shadow state
  function automatic vec_t gate_and_limit(input vec_t cur);
    logic signed [63:0] dx, dy, dz;
    logic [63:0]        moved;
    vec_t               pick;
    dx = cur.x - last_in.x;
    dy = cur.y - last_in.y;
    dz = cur.z - last_in.z;
    moved = square(dx) + square(dy) + square(dz);
    if (first_pending) pick = NO_MOTION;
    else if (moved > 64'(thr_reg) * 64'(thr_reg)) pick = limit_norm(cur);
    else pick = limit_norm(last_in);
    last_in       = cur;
    first_pending = 1'b0;
    return pick;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic vec_t mk_vec(input int a, input int b, input int c);
    vec_t v;
    v.x = a[SW-1:0];
    v.y = b[SW-1:0];
    v.z = c[SW-1:0];
    return v;
  endfunction

  function automatic row_t fixed_row(input vec_t v, input vec_t w);
    row_t r;
    r.kind  = ROW_WORD;
    r.addr  = REG_CHANGE_THRESHOLD;
    r.data  = '0;
    r.word  = v;
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic row_t check_row(input vec_t v);
    row_t r;
    r       = fixed_row(v, NO_MOTION);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_INDEX_WIDTH-1:0] addr,
                                   input logic [CFG_WIDTH-1:0] data);
    row_t r;
    r      = fixed_row(NO_MOTION, NO_MOTION);
    r.kind = ROW_CFG;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  function automatic samp_t clip(input int a);
    if (a > 32767) return samp_t'(32767);
    if (a < -32768) return samp_t'(-32768);
    return a[SW-1:0];
  endfunction

  function automatic samp_t jitter(input samp_t c, input int span);
    return clip(int'(c) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic samp_t corner_val();
    case ($urandom_range(0, 4))
      0: return samp_t'(-32768);
      1: return samp_t'(32767);
      2: return samp_t'(0);
      3: return samp_t'(-1);
      default: return samp_t'(1);
    endcase
  endfunction

  function automatic vec_t make_word();
    vec_t v;
    int   r;
    int   span;
    int   step;
    r = $urandom_range(0, 99);
    v = last_sent;
    if (r < 35) begin
      // small moves around the previous word, straddling the threshold
      span = int'(thr_reg) + 2;
      v.x = jitter(last_sent.x, span);
      v.y = jitter(last_sent.y, span);
      v.z = jitter(last_sent.z, span);
    end else if (r < 45) begin
      // one axis moved by exactly the threshold or one more
      step = int'(thr_reg) + int'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 1) step = -step;
      case ($urandom_range(0, 2))
        0: v.x = clip(int'(v.x) + step);
        1: v.y = clip(int'(v.y) + step);
        default: v.z = clip(int'(v.z) + step);
      endcase
    end else if (r < 65) begin
      // magnitudes near the speed limit
      span = int'(max_reg) * 3 / 5 + 1;
      v.x = jitter(samp_t'(0), span);
      v.y = jitter(samp_t'(0), span);
      v.z = jitter(samp_t'(0), span);
    end else if (r < 85) begin
      v.x = samp_t'($urandom);
      v.y = samp_t'($urandom);
      v.z = samp_t'($urandom);
    end else begin
      v.x = corner_val();
      v.y = corner_val();
      v.z = corner_val();
    end
    return v;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 70);
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input vec_t v, input bit typed, input vec_t typed_want);
    int   gap;
    vec_t pred;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    vel_x    = v.x;
    vel_y    = v.y;
    vel_z    = v.z;
    do @(posedge clk); while (!in_ready);
    pred = gate_and_limit(v);
    pending_refs.push_back(typed ? typed_want : pred);
    last_sent = v;
    @(negedge clk);
  endtask

  // hold off input until every pending word is out
  task automatic settle_block();
    in_valid = 1'b0;
    while (pending_refs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] addr,
                           input logic [CFG_WIDTH-1:0] data);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == REG_CHANGE_THRESHOLD) thr_reg = data;
    else if (addr == REG_MAX_SPEED) max_reg = data;
  endtask

  // output side stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      int hold;
      hold = pick_gap(rx_quiet);
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input samp_t exp_v, input samp_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_refs.size() == 0) begin
        $error("output word with nothing pending: %0d %0d %0d", ref_x, ref_y, ref_z);
        errors++;
      end else begin
        want = pending_refs.pop_front();
        check_field("ref_x", want.x, ref_x);
        check_field("ref_y", want.y, ref_y);
        check_field("ref_z", want.z, ref_z);
      end
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin
    logic [CFG_WIDTH-1:0] thr_plan [PHASES];
    logic [CFG_WIDTH-1:0] max_plan [PHASES];

    errors   = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rst      = 1'b1;
    in_valid = 1'b0;
    vel_x    = '0;
    vel_y    = '0;
    vel_z    = '0;
    cfg_we   = 1'b0;
    cfg_addr = REG_CHANGE_THRESHOLD;
    cfg_data = '0;

    thr_reg       = CHANGE_THRESHOLD_RESET;
    max_reg       = MAX_SPEED_RESET;
    last_in       = NO_MOTION;
    last_sent     = NO_MOTION;
    first_pending = 1'b1;

    // directed rows, defaults: threshold 410, limit 3072
    script.push_back(fixed_row(mk_vec(32767, -32768, 4660), NO_MOTION));  // first word
    script.push_back(check_row(mk_vec(32767, -32768, 4660)));  // unchanged, clamped
    script.push_back(fixed_row(mk_vec(0, 0, 0), NO_MOTION));
    script.push_back(fixed_row(mk_vec(410, 0, 0), NO_MOTION));  // change equals threshold
    script.push_back(fixed_row(mk_vec(821, 0, 0), mk_vec(821, 0, 0)));
    script.push_back(fixed_row(mk_vec(3072, 0, 0), mk_vec(3072, 0, 0)));  // norm at limit
    script.push_back(fixed_row(mk_vec(0, -3073, 0), mk_vec(0, -3072, 0)));
    script.push_back(check_row(mk_vec(-32768, -32768, -32768)));
    script.push_back(check_row(mk_vec(32767, 32767, 32767)));
    // zero speed limit
    script.push_back(cfg_row(REG_MAX_SPEED, 15'd0));
    script.push_back(fixed_row(mk_vec(0, 0, 5), NO_MOTION));
    script.push_back(fixed_row(mk_vec(0, 0, 0), NO_MOTION));
    script.push_back(cfg_row(REG_CHANGE_THRESHOLD, 15'd32767));
    script.push_back(fixed_row(mk_vec(-32768, 32767, 0), NO_MOTION));
    script.push_back(cfg_row(REG_MAX_SPEED, 15'd32767));
    script.push_back(check_row(mk_vec(-32768, -32768, -32768)));
    script.push_back(check_row(mk_vec(-32768, -32768, -32760)));
    // zero threshold, identical word keeps the previous one
    script.push_back(cfg_row(REG_CHANGE_THRESHOLD, 15'd0));
    script.push_back(check_row(mk_vec(-32768, -32768, -32760)));
    script.push_back(fixed_row(mk_vec(1, 0, 0), mk_vec(1, 0, 0)));
    // writes past the register list must not land anywhere
    script.push_back(cfg_row(REG_SPARE_A, 15'h7fff));
    script.push_back(cfg_row(REG_SPARE_B, 15'd0));
    script.push_back(fixed_row(mk_vec(2, 0, 0), mk_vec(2, 0, 0)));

    thr_plan = '{15'd410, 15'd0, 15'd32767, 15'd0, 15'd32767,
                 15'($urandom_range(0, 32767)), 15'($urandom_range(20, 300))};
    max_plan = '{15'd3072, 15'd0, 15'd32767, 15'd32767, 15'd0,
                 15'($urandom_range(0, 32767)), 15'($urandom_range(1000, 8000))};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(script[i].addr, script[i].data);
      end else begin
        send_word(script[i].word, script[i].typed, script[i].want);
      end
    end

    // random phases, registers change only with the block drained
    for (int p = 0; p < PHASES; p++) begin
      tx_quiet = (p == 2);
      rx_quiet = (p == 2 || p == 5);
      settle_block();
      write_reg(REG_CHANGE_THRESHOLD, thr_plan[p]);
      write_reg(REG_MAX_SPEED, max_plan[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 149) == 0) settle_block();
        send_word(make_word(), 1'b0, NO_MOTION);
      end
    end

    settle_block();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/vcg_pkg.sv
hw/rtl/vcg_mul.sv
hw/rtl/vcg_rootdiv.sv
hw/rtl/velocity_change_gate_norm_limiter.sv
dv/tb_top.sv
